// File: sv/gost_block_cipher_with_counter_mode_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the GOST cipher unit
// Each macro expands to one labeled concurrent assertion on clk, held off
// while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GOST_BLOCK_CIPHER_WITH_COUNTER_MODE_UNIT_ASSERT_SVH
`define GOST_BLOCK_CIPHER_WITH_COUNTER_MODE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GOST_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GOST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/gost_pkg.sv
// ----------------------------------------------------------------------------
// GOST cipher package
// Opcodes, counter-mode constants, the S-box table and the helper
// functions used by the cipher unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gost_pkg;

  localparam int DATA_W     = 64;
  localparam int WORD_W     = 32;
  localparam int NUM_KREGS  = 4;
  localparam int NUM_KWORDS = 8;
  localparam int KIDX_W     = 3;
  localparam int KREG_W     = 2;
  localparam int CFG_ADDR_W = 5;
  localparam int ROUNDS     = 32;
  localparam int RND_W      = 5;
  localparam int ROT        = 11;
  localparam int CNT_W      = 4;

  // Operation codes carried by the opcode field.
  localparam logic [1:0] OP_ENCRYPT = 2'd0;
  localparam logic [1:0] OP_DECRYPT = 2'd1;
  localparam logic [1:0] OP_LOAD_IV = 2'd2;
  localparam logic [1:0] OP_CTR     = 2'd3;

  // Counter step constants for the low and high words.
  localparam logic [WORD_W-1:0] GAMMA_C1 = 32'h0101_0101;
  localparam logic [WORD_W-1:0] GAMMA_C2 = 32'h0101_0104;

  localparam logic [CNT_W-1:0] FULL_BYTES = 4'd8;
  localparam logic [RND_W-1:0] LAST_RND   = 5'd31;
  localparam logic [RND_W-1:0] DEC_FWD_END = 5'd8;
  localparam logic [RND_W-1:0] ENC_FWD_END = 5'd24;

  // Fixed S-box set, one row of sixteen entries per nibble position.
  localparam logic [3:0] SBOX [NUM_KWORDS][16] = '{
    '{4'd4,  4'd10, 4'd9,  4'd2,  4'd13, 4'd8,  4'd0,  4'd14,
      4'd6,  4'd11, 4'd1,  4'd12, 4'd7,  4'd15, 4'd5,  4'd3},
    '{4'd14, 4'd11, 4'd4,  4'd12, 4'd6,  4'd13, 4'd15, 4'd10,
      4'd2,  4'd3,  4'd8,  4'd1,  4'd0,  4'd7,  4'd5,  4'd9},
    '{4'd5,  4'd8,  4'd1,  4'd13, 4'd10, 4'd3,  4'd4,  4'd2,
      4'd14, 4'd15, 4'd12, 4'd7,  4'd6,  4'd0,  4'd9,  4'd11},
    '{4'd7,  4'd13, 4'd10, 4'd1,  4'd0,  4'd8,  4'd9,  4'd15,
      4'd14, 4'd4,  4'd6,  4'd12, 4'd11, 4'd2,  4'd5,  4'd3},
    '{4'd6,  4'd12, 4'd7,  4'd1,  4'd5,  4'd15, 4'd13, 4'd8,
      4'd4,  4'd10, 4'd9,  4'd14, 4'd0,  4'd3,  4'd11, 4'd2},
    '{4'd4,  4'd11, 4'd10, 4'd0,  4'd7,  4'd2,  4'd1,  4'd13,
      4'd3,  4'd6,  4'd8,  4'd5,  4'd9,  4'd12, 4'd15, 4'd14},
    '{4'd13, 4'd11, 4'd4,  4'd1,  4'd3,  4'd15, 4'd5,  4'd9,
      4'd0,  4'd10, 4'd14, 4'd7,  4'd6,  4'd8,  4'd2,  4'd12},
    '{4'd1,  4'd15, 4'd13, 4'd0,  4'd5,  4'd7,  4'd10, 4'd4,
      4'd9,  4'd2,  4'd3,  4'd14, 4'd6,  4'd11, 4'd8,  4'd12}
  };

  // Substitute every nibble of a word through the row of its position.
  function automatic logic [WORD_W-1:0] sbox_sub(input logic [WORD_W-1:0] x);
    logic [WORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_KWORDS; i++) begin
      r[4*i +: 4] = SBOX[i][x[4*i +: 4]];
    end
    return r;
  endfunction

  // Step the counter: low word mod 2^32, high word mod 2^32-1.
  function automatic logic [DATA_W-1:0] step_counter(input logic [DATA_W-1:0] c);
    logic [WORD_W:0]   hs;
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
    hs = {1'b0, c[DATA_W-1:WORD_W]} + {1'b0, GAMMA_C2};
    hi = hs[WORD_W-1:0] + {{(WORD_W-1){1'b0}}, hs[WORD_W]};
    lo = c[WORD_W-1:0] + GAMMA_C1;
    return {hi, lo};
  endfunction

  // Keep the low cnt bytes of a word.
  function automatic logic [DATA_W-1:0] byte_mask(input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[8*i +: 8] = (CNT_W'(i) < cnt) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage

// File: sv/gost_regs.sv
// ----------------------------------------------------------------------------
// GOST key register file
// Four 64-bit key registers behind an APB-style port, plus the key word
// selector that feeds the round unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gost_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [gost_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [gost_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready,
  input  logic [gost_pkg::KIDX_W-1:0]     key_idx,
  output logic [gost_pkg::WORD_W-1:0]     key_word
);
  import gost_pkg::*;

  logic [DATA_W-1:0] key_r [NUM_KREGS];
  logic [DATA_W-1:0] prdata_r;
  logic [KREG_W-1:0] reg_sel;
  logic              wr_en;
  logic [DATA_W-1:0] sel_reg;

  // Registers sit on 8-byte boundaries.
  assign reg_sel = cfg_paddr[CFG_ADDR_W-1:3];
  assign wr_en   = cfg_psel && cfg_penable && cfg_pwrite;

  // Key registers are written in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KREGS; i++) begin
        key_r[i] <= '0;
      end
    end else if (wr_en) begin
      key_r[reg_sel] <= cfg_pwdata;
    end
  end

  // Read data is fetched in the setup phase and shown in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prdata_r <= '0;
    end else if (cfg_psel && !cfg_penable) begin
      prdata_r <= key_r[reg_sel];
    end
  end

  assign cfg_prdata = prdata_r;
  assign cfg_pready = 1'b1;

  // Even key words are the low halves, odd ones the high halves.
  assign sel_reg  = key_r[key_idx[KIDX_W-1:1]];
  assign key_word = key_idx[0] ? sel_reg[DATA_W-1:WORD_W] : sel_reg[WORD_W-1:0];

endmodule

// File: sv/gost_round.sv
// ----------------------------------------------------------------------------
// GOST round unit
// One Feistel round: key add, S-box substitution, rotate by eleven and
// XOR into the other half.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost_round (
  input  logic [gost_pkg::WORD_W-1:0] half_a,
  input  logic [gost_pkg::WORD_W-1:0] half_b,
  input  logic [gost_pkg::WORD_W-1:0] key_word,
  output logic [gost_pkg::WORD_W-1:0] new_a
);
  import gost_pkg::*;

  logic [WORD_W-1:0] sum;
  logic [WORD_W-1:0] sub;
  logic [WORD_W-1:0] rot;

  // Key add modulo 2^32, then the nibble substitution.
  assign sum = half_a + key_word;
  assign sub = sbox_sub(sum);

  // Rotate left by eleven and mix into the second half.
  assign rot   = {sub[WORD_W-ROT-1:0], sub[WORD_W-1:WORD_W-ROT]};
  assign new_a = rot ^ half_b;

endmodule

// File: sv/gost_block_cipher_with_counter_mode_unit.sv
// ----------------------------------------------------------------------------
// GOST 28147-89 cipher unit with counter mode
// Encrypts or decrypts a 64-bit block, loads an IV (the counter becomes the
// encrypted IV and the result word is zero) or runs one counter-mode step
// (the counter steps, is encrypted, and the keystream is XORed into the data
// with bytes beyond byte_count cleared). A block runs through 32 rounds on
// one shared round unit, one round per clock. The last round also forms the
// result, which the result stage then moves into the output register; the
// unit goes back to idle with that move and only then accepts the next word.
// A counter-mode word with a byte count of zero skips the rounds: its result
// goes straight to the result stage. The unit takes one item at a time; a
// finished result waits in the output register while the next item is
// already running, and the result stage holds off for as long as that
// register still carries a word the receiver has not taken. The four 64-bit
// key registers sit at byte addresses 0, 8, 16 and 24.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gost_block_cipher_with_counter_mode_unit_assert.svh"

module gost_block_cipher_with_counter_mode_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_opcode,
  input  logic [gost_pkg::DATA_W-1:0]     in_data,
  input  logic [gost_pkg::CNT_W-1:0]      in_byte_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [gost_pkg::DATA_W-1:0]     out_result_data,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [gost_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [gost_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [gost_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                            cfg_pready
);
  import gost_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]        state_r,   state_nxt;
  logic [RND_W-1:0]  rnd_r,     rnd_nxt;
  logic [1:0]        op_r,      op_nxt;
  logic [DATA_W-1:0] data_r,    data_nxt;
  logic [CNT_W-1:0]  cnt_r,     cnt_nxt;
  logic [WORD_W-1:0] a_r,       a_nxt;
  logic [WORD_W-1:0] b_r,       b_nxt;
  logic [DATA_W-1:0] res_r,     res_nxt;
  logic [DATA_W-1:0] counter_r, counter_nxt;
  logic              ovalid_r,  ovalid_nxt;
  logic [DATA_W-1:0] odata_r,   odata_nxt;

  logic [KIDX_W-1:0] key_idx;
  logic [WORD_W-1:0] key_word;
  logic [WORD_W-1:0] new_a;
  logic [DATA_W-1:0] blk_out;
  logic [DATA_W-1:0] ctr_step;
  logic [CNT_W-1:0]  in_cnt_sat;
  logic              in_acc;
  logic              out_free;

  // Key registers and configuration port.
  gost_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .key_idx     (key_idx),
    .key_word    (key_word)
  );

  // Shared round unit.
  gost_round u_round (
    .half_a   (a_r),
    .half_b   (b_r),
    .key_word (key_word),
    .new_a    (new_a)
  );

  // Key schedule: forward passes first, then one reversed pass for
  // encryption; one forward pass then reversed passes for decryption.
  always_comb begin
    if (op_r == OP_DECRYPT) begin
      key_idx = (rnd_r < DEC_FWD_END) ? rnd_r[KIDX_W-1:0] : ~rnd_r[KIDX_W-1:0];
    end else begin
      key_idx = (rnd_r < ENC_FWD_END) ? rnd_r[KIDX_W-1:0] : ~rnd_r[KIDX_W-1:0];
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign out_free   = !ovalid_r || out_ready;
  assign ctr_step   = step_counter(counter_r);
  assign in_cnt_sat = (in_byte_count > FULL_BYTES) ? FULL_BYTES : in_byte_count;

  // Halves are swapped back after the last round.
  assign blk_out = {new_a, a_r};

  // Sequencer: load, 32 rounds (none for empty CTR words), result, output.
  always_comb begin
    state_nxt   = state_r;
    rnd_nxt     = rnd_r;
    op_nxt      = op_r;
    data_nxt    = data_r;
    cnt_nxt     = cnt_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    res_nxt     = res_r;
    counter_nxt = counter_r;
    ovalid_nxt  = ovalid_r;
    odata_nxt   = odata_r;

    if (ovalid_r && out_ready) begin
      ovalid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt   = in_opcode;
          data_nxt = in_data;
          cnt_nxt  = in_cnt_sat;
          rnd_nxt  = '0;
          if (in_opcode == OP_CTR) begin
            if (in_byte_count == '0) begin
              res_nxt   = '0;
              state_nxt = ST_FIN;
            end else begin
              counter_nxt = ctr_step;
              a_nxt       = ctr_step[WORD_W-1:0];
              b_nxt       = ctr_step[DATA_W-1:WORD_W];
              state_nxt   = ST_RUN;
            end
          end else begin
            a_nxt     = in_data[WORD_W-1:0];
            b_nxt     = in_data[DATA_W-1:WORD_W];
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        a_nxt   = new_a;
        b_nxt   = a_r;
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = ST_FIN;
          case (op_r)
            OP_LOAD_IV: begin
              counter_nxt = blk_out;
              res_nxt     = '0;
            end
            OP_CTR: begin
              res_nxt = (data_r ^ blk_out) & byte_mask(cnt_r);
            end
            default: begin
              res_nxt = blk_out;
            end
          endcase
        end
      end
      ST_FIN: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = res_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rnd_r     <= '0;
      ovalid_r  <= 1'b0;
      counter_r <= '0;
      op_r      <= OP_ENCRYPT;
    end else begin
      state_r   <= state_nxt;
      rnd_r     <= rnd_nxt;
      ovalid_r  <= ovalid_nxt;
      counter_r <= counter_nxt;
      op_r      <= op_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    data_r  <= data_nxt;
    cnt_r   <= cnt_nxt;
    a_r     <= a_nxt;
    b_r     <= b_nxt;
    res_r   <= res_nxt;
    odata_r <= odata_nxt;
  end

  assign out_valid       = ovalid_r;
  assign out_result_data = odata_r;

  // An accepted word always starts work.
  `GOST_ASSERT_NEXT(a_accept_starts, in_acc, (state_r == ST_RUN) || (state_r == ST_FIN), "accepted word did not start")
  // The last round always leads to the result stage.
  `GOST_ASSERT_NEXT(a_last_round_fin, (state_r == ST_RUN) && (rnd_r == LAST_RND), state_r == ST_FIN, "round count overran")
  // A counter-mode word with bytes steps the counter's low word.
  `GOST_ASSERT_NEXT(a_ctr_steps, in_acc && (in_opcode == OP_CTR) && (in_byte_count != '0), counter_r[WORD_W-1:0] != $past(counter_r[WORD_W-1:0]), "counter did not step")
  // Block operations leave the counter alone.
  `GOST_ASSERT_NEXT(a_blk_keeps_ctr, in_acc && ((in_opcode == OP_ENCRYPT) || (in_opcode == OP_DECRYPT)), $stable(counter_r), "counter changed on a block operation")

endmodule

// File: bench/gost_block_cipher_with_counter_mode_unit_tb.sv
// ----------------------------------------------------------------------------
// Testbench for the GOST cipher unit with counter mode
// Words are fed through the valid/ready input channel by a clocked driver
// that pops a queue of pending words. Each accepted word is run through a
// local cipher predictor that keeps its own copy of the key and the counter.
// A clocked monitor compares every result word with the oldest expected
// value. Key registers are rewritten over the APB port between phases,
// and the phases use several patterns of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gost_block_cipher_with_counter_mode_unit_tb;
  import gost_pkg::*;

  localparam int          WATCHDOG_LIMIT = 5000;
  localparam int          SETTLE_CYCLES  = 40;
  localparam logic [31:0] STEP_LO        = 32'h0101_0101;
  localparam logic [31:0] STEP_HI        = 32'h0101_0104;

  // Substitution rows, one per nibble position of a half block.
  localparam logic [3:0] SUBST [8][16] = '{
    '{4, 10, 9, 2, 13, 8, 0, 14, 6, 11, 1, 12, 7, 15, 5, 3},
    '{14, 11, 4, 12, 6, 13, 15, 10, 2, 3, 8, 1, 0, 7, 5, 9},
    '{5, 8, 1, 13, 10, 3, 4, 2, 14, 15, 12, 7, 6, 0, 9, 11},
    '{7, 13, 10, 1, 0, 8, 9, 15, 14, 4, 6, 12, 11, 2, 5, 3},
    '{6, 12, 7, 1, 5, 15, 13, 8, 4, 10, 9, 14, 0, 3, 11, 2},
    '{4, 11, 10, 0, 7, 2, 1, 13, 3, 6, 8, 5, 9, 12, 15, 14},
    '{13, 11, 4, 1, 3, 15, 5, 9, 0, 10, 14, 7, 6, 8, 2, 12},
    '{1, 15, 13, 0, 5, 7, 10, 4, 9, 2, 3, 14, 6, 11, 8, 12}
  };

  typedef struct {
    logic [1:0]        opcode;
    logic [DATA_W-1:0] data;
    logic [CNT_W-1:0]  byte_count;
  } cipher_word_t;

  logic                  clk;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_opcode     = '0;
  logic [DATA_W-1:0]     in_data       = '0;
  logic [CNT_W-1:0]      in_byte_count = '0;
  logic                  out_valid;
  logic                  out_ready     = 1'b0;
  logic [DATA_W-1:0]     out_result_data;
  logic                  cfg_psel      = 1'b0;
  logic                  cfg_penable   = 1'b0;
  logic                  cfg_pwrite    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr     = '0;
  logic [DATA_W-1:0]     cfg_pwdata    = '0;
  logic [DATA_W-1:0]     cfg_prdata;
  logic                  cfg_pready;

  gost_block_cipher_with_counter_mode_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_data         (in_data),
    .in_byte_count   (in_byte_count),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_data (out_result_data),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  // Predictor state: key words and the counter-mode counter.
  logic [31:0]       key_w [8] = '{default: '0};
  logic [DATA_W-1:0] ctr_state = '0;

  cipher_word_t      pending_words [$];
  logic [DATA_W-1:0] expected_results [$];
  int                words_queued  = 0;
  int                results_seen  = 0;
  int                idle_pct      = 0;
  int                stall_pct     = 0;
  int                quiet_cycles  = 0;
  bit                in_taken      = 1'b0;
  bit                run_failed    = 1'b0;
  cipher_word_t      next_word;
  cipher_word_t      taken_word;
  logic [DATA_W-1:0] want;

  // Clock with a 2 ns period.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // One round function: key add, nibble substitution, rotate left by 11.
  function automatic logic [31:0] round_mix(input logic [31:0] half, input logic [31:0] k);
    logic [31:0] s;
    logic [31:0] r;
    s = half + k;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = SUBST[i][s[4*i +: 4]];
    end
    return {r[20:0], r[31:21]};
  endfunction

  // Full 32-round pass over a block with the current key schedule.
  function automatic logic [DATA_W-1:0] gost_rounds(input logic [DATA_W-1:0] blk,
                                                    input bit decrypt);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] t;
    int          idx;
    a = blk[31:0];
    b = blk[63:32];
    for (int i = 0; i < 32; i++) begin
      if (decrypt) idx = (i < 8) ? i : 7 - (i % 8);
      else idx = (i < 24) ? i % 8 : 7 - (i % 8);
      t = round_mix(a, key_w[idx]) ^ b;
      b = a;
      a = t;
    end
    return {a, b};
  endfunction

  // Low word steps mod 2^32, high word mod 2^32-1 with end-around carry.
  function automatic logic [DATA_W-1:0] counter_advance(input logic [DATA_W-1:0] c);
    logic [32:0] hs;
    logic [31:0] hi;
    hs = {1'b0, c[63:32]} + {1'b0, STEP_HI};
    hi = hs[31:0] + {31'd0, hs[32]};
    return {hi, c[31:0] + STEP_LO};
  endfunction

  // Expected result of one accepted word; updates the counter.
  function automatic logic [DATA_W-1:0] cipher_predict(input cipher_word_t w);
    logic [DATA_W-1:0] mask;
    int                n;
    case (w.opcode)
      OP_ENCRYPT: return gost_rounds(w.data, 1'b0);
      OP_DECRYPT: return gost_rounds(w.data, 1'b1);
      OP_LOAD_IV: begin
        ctr_state = gost_rounds(w.data, 1'b0);
        return '0;
      end
      default: begin
        if (w.byte_count == 0) return '0;
        n = (w.byte_count > 8) ? 8 : int'(w.byte_count);
        ctr_state = counter_advance(ctr_state);
        mask = '0;
        for (int i = 0; i < 8; i++) begin
          if (i < n) mask[8*i +: 8] = 8'hFF;
        end
        return (w.data ^ gost_rounds(ctr_state, 1'b0)) & mask;
      end
    endcase
  endfunction

  // Input driver: presents the next word at the falling edge.
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_words.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_word = pending_words.pop_front();
        in_opcode     <= next_word.opcode;
        in_data       <= next_word.data;
        in_byte_count <= next_word.byte_count;
        in_valid      <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
  end

  // Monitor: predicts on input acceptance, checks on output acceptance.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        taken_word = '{in_opcode, in_data, in_byte_count};
        expected_results.push_back(cipher_predict(taken_word));
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word %h arrived with no word outstanding", out_result_data);
          run_failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (out_result_data !== want) begin
            $error("result_data mismatch: expected %h, actual %h", want, out_result_data);
            run_failed = 1'b1;
          end
          results_seen++;
        end
      end
      // Watchdog on cycles with no handshake on either channel.
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired after %0d quiet cycles", quiet_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic push_word(input logic [1:0] op, input logic [DATA_W-1:0] d,
                           input logic [CNT_W-1:0] cnt);
    pending_words.push_back('{op, d, cnt});
    words_queued++;
  endtask

  // Block until every queued word has produced its result, then let it settle.
  task automatic wait_drained();
    while (results_seen != words_queued) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // APB write: setup cycle, then access cycle.
  task automatic key_write(input int idx, input logic [DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(idx * 8);
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    key_w[2*idx]   = val[31:0];
    key_w[2*idx+1] = val[63:32];
  endtask

  task automatic set_keys(input logic [DATA_W-1:0] k01, input logic [DATA_W-1:0] k23,
                          input logic [DATA_W-1:0] k45, input logic [DATA_W-1:0] k67);
    key_write(0, k01);
    key_write(1, k23);
    key_write(2, k45);
    key_write(3, k67);
  endtask

  function automatic logic [DATA_W-1:0] rand_data();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(63);
      3: return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Mostly full blocks, with partial tails, zero counts and oversized counts.
  function automatic logic [CNT_W-1:0] rand_count();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 4'd8;
    if (r < 88) return CNT_W'($urandom_range(1, 7));
    if (r < 94) return 4'd0;
    return CNT_W'($urandom_range(9, 15));
  endfunction

  // Random words: mostly IV loads followed by counter-mode streams.
  task automatic fill_random(input int n);
    int added;
    int k;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 40) begin
        push_word(OP_LOAD_IV, rand_data(), CNT_W'($urandom_range(15)));
        k = $urandom_range(2, 10);
        for (int j = 0; j < k; j++) push_word(OP_CTR, rand_data(), rand_count());
        added += k + 1;
      end else begin
        k = $urandom_range(3);
        push_word(2'(k), rand_data(),
                  (2'(k) == OP_CTR) ? rand_count() : CNT_W'($urandom_range(15)));
        added++;
      end
    end
  endtask

  task automatic run_phase(input int n, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    @(posedge clk);
    fill_random(n);
    wait_drained();
  endtask

  // Stimulus sequence.
  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed words with the reset key of all zeros.
    push_word(OP_ENCRYPT, '0, 4'd8);
    push_word(OP_ENCRYPT, '1, 4'd8);
    push_word(OP_DECRYPT, '0, 4'd8);
    push_word(OP_DECRYPT, '1, 4'd15);
    push_word(OP_ENCRYPT, 64'h0123_4567_89AB_CDEF, 4'd0);
    push_word(OP_DECRYPT, 64'h0123_4567_89AB_CDEF, 4'd3);
    // Counter mode before any IV load runs from the zero counter.
    push_word(OP_CTR, '1, 4'd8);
    push_word(OP_LOAD_IV, '0, 4'd0);
    push_word(OP_CTR, '1, 4'd1);
    push_word(OP_CTR, '1, 4'd7);
    push_word(OP_CTR, 64'hA5A5_5A5A_F00F_0FF0, 4'd8);
    // A zero count leaves the counter alone; counts above eight saturate.
    push_word(OP_CTR, '1, 4'd0);
    push_word(OP_CTR, '1, 4'd9);
    push_word(OP_CTR, '1, 4'd15);
    // Counter words that wrap the low word and carry around in the high word.
    push_word(OP_LOAD_IV, gost_rounds({32'hFFFF_FFFE, 32'hFFFF_FFFF}, 1'b1), 4'd8);
    push_word(OP_CTR, '1, 4'd8);
    push_word(OP_CTR, '0, 4'd8);
    // High word that lands exactly on all ones, then overflows on the next step.
    push_word(OP_LOAD_IV, gost_rounds({32'hFEFE_FEFB, 32'h0000_0000}, 1'b1), 4'd15);
    push_word(OP_CTR, '0, 4'd8);
    push_word(OP_CTR, '0, 4'd4);
    push_word(OP_LOAD_IV, '1, 4'd8);
    push_word(OP_CTR, '0, 4'd3);
    push_word(OP_CTR, '1, 4'd2);
    wait_drained();

    set_keys('1, '1, '1, '1);
    run_phase(300, 0, 0);

    set_keys({$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(400, 65, 0);

    set_keys({$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(400, 0, 65);

    set_keys(64'h5555_5555_AAAA_AAAA, 64'hAAAA_AAAA_5555_5555,
             64'h0000_0000_FFFF_FFFF, 64'hFFFF_FFFF_0000_0000);
    run_phase(400, 10, 10);

    set_keys({$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    run_phase(325, 0, 0);

    if (run_failed) begin
      $display("*** FAILED ***");
    end else begin
      $display("*** PASSED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/gost_pkg.sv
sv/gost_regs.sv
sv/gost_round.sv
sv/gost_block_cipher_with_counter_mode_unit.sv
bench/gost_block_cipher_with_counter_mode_unit_tb.sv
